>>> rtl/ldq_pkg.sv
// ----------------------------------------------------------------------------
// ldq_pkg
// Shared constants, codes and types of the linear-array deque.
// ----------------------------------------------------------------------------
package ldq_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int MARK_W     = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int SIZE_W   = 5;
  localparam int SIZE_RST = 16;

  // Stream packing, padded to whole bytes
  localparam int IN_BITS  = MODE_W + DATA_WIDTH;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = DATA_WIDTH + STATUS_W + OCC_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_BITS;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Result bookkeeping carried alongside the slot read
  typedef struct packed {
    status_t          status;
    logic [OCC_W-1:0] occ;
    logic             from_ram;
  } rsp_meta_t;

endpackage

>>> rtl/ldq_ram.sv
// ----------------------------------------------------------------------------
// ldq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ldq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read; read data holds between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/linear_array_deque_core.sv
// ----------------------------------------------------------------------------
// linear_array_deque_core
// Double-ended queue of data words held in a linear (non-circular) array.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in_ stream is one operation: push front, push rear,
//   pop front or pop rear. Every request yields exactly one response on the
//   out_ stream carrying the popped word (all ones for pushes and refused
//   pops), a status (done, full, empty) and the occupancy after the request.
//   The front and rear marks live in flops; the words live in a 16-entry RAM
//   with a registered read. A request updates the marks and issues
//   its slot write or read in the cycle it is accepted; the read data lands
//   in the output register when stage 1 advances into it.
//   Throughput: one request per cycle while in_tready is high; a request
//   needs at most one RAM port access.
//   Back-pressure: an internal stage and the output register hold up to two
//   responses; in_tready drops only while both are full and out_tready is low.
//   Reset: marks clear (queue empty), active_size returns to 16, no response
//   is pending. RAM contents are not cleared.
//   cfg_wr_en writes active_size, which bounds rear pushes; write it idle.
// ----------------------------------------------------------------------------
module linear_array_deque_core
  import ldq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Request stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,     // [1:0] mode, [33:2] value_in
  // Response stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,    // [31:0] value_out, [33:32] status,
                                          // [38:34] occupancy
  // Configuration
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data   // active_size
);

  logic [MARK_W-1:0]     front_r, front_nxt;
  logic [MARK_W-1:0]     rear_r, rear_nxt;
  logic [SIZE_W-1:0]     active_size_r;
  logic [MARK_W-1:0]     eff_size;

  logic                  s1_valid_r;
  rsp_meta_t             s1_meta_r, s1_meta_nxt;
  logic                  s1_adv;

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_value_r;
  status_t               out_status_r;
  logic [OCC_W-1:0]      out_occ_r;

  logic                  in_fire;
  mode_t                 req_mode;
  logic [DATA_WIDTH-1:0] req_value;
  logic                  is_empty;

  logic                  ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0]     ram_wr_addr, ram_rd_addr;
  logic [DATA_WIDTH-1:0] ram_rd_data;

  // Unpack request
  assign req_mode  = mode_t'(in_tdata[MODE_W-1:0]);
  assign req_value = in_tdata[MODE_W +: DATA_WIDTH];

  // Handshake: stage 1 advances when the output register is free or drains
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign is_empty = (front_r == rear_r);

  // Clamp the configured size to the array depth
  assign eff_size = (int'(active_size_r) > DEPTH) ? MARK_W'(DEPTH)
                                                  : MARK_W'(active_size_r);

  // Decode the operation, move the marks and address at most one slot
  always_comb begin
    front_nxt          = front_r;
    rear_nxt           = rear_r;
    ram_wr_en          = 1'b0;
    ram_rd_en          = 1'b0;
    ram_wr_addr        = '0;
    ram_rd_addr        = '0;
    s1_meta_nxt.status = ST_DONE;
    s1_meta_nxt.from_ram = 1'b0;
    if (in_fire) begin
      unique case (req_mode)
        MODE_PUSH_FRONT: begin
          if (front_r == '0) begin
            s1_meta_nxt.status = ST_FULL;
          end else begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(front_r - MARK_W'(1));
            front_nxt   = front_r - MARK_W'(1);
          end
        end
        MODE_PUSH_REAR: begin
          if (rear_r >= eff_size) begin
            s1_meta_nxt.status = ST_FULL;
          end else if (is_empty) begin
            // restart an empty queue at the array start
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            front_nxt   = '0;
            rear_nxt    = MARK_W'(1);
          end else begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(rear_r);
            rear_nxt    = rear_r + MARK_W'(1);
          end
        end
        MODE_POP_FRONT: begin
          if (is_empty) begin
            s1_meta_nxt.status = ST_EMPTY;
          end else begin
            ram_rd_en            = 1'b1;
            ram_rd_addr          = ADDR_W'(front_r);
            s1_meta_nxt.from_ram = 1'b1;
            front_nxt            = front_r + MARK_W'(1);
          end
        end
        MODE_POP_REAR: begin
          if (is_empty) begin
            s1_meta_nxt.status = ST_EMPTY;
          end else begin
            ram_rd_en            = 1'b1;
            ram_rd_addr          = ADDR_W'(rear_r - MARK_W'(1));
            s1_meta_nxt.from_ram = 1'b1;
            rear_nxt             = rear_r - MARK_W'(1);
          end
        end
        default: begin
          s1_meta_nxt.status = ST_DONE;
        end
      endcase
    end
    s1_meta_nxt.occ = OCC_W'(rear_nxt - front_nxt);
  end

  ldq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (req_value),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Marks and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r       <= '0;
      rear_r        <= '0;
      active_size_r <= SIZE_W'(SIZE_RST);
    end else begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      if (cfg_wr_en) begin
        active_size_r <= cfg_wr_data;
      end
    end
  end

  // Stage 1: hold response bookkeeping while the slot read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_meta_r <= s1_meta_nxt;
    end
  end

  // Output register: advance stage 1, drop on acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_value_r  <= s1_meta_r.from_ram ? ram_rd_data : '1;
      out_status_r <= s1_meta_r.status;
      out_occ_r    <= s1_meta_r.occ;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD'(0), out_occ_r, out_status_r, out_value_r};

  // Marks never cross and never pass the array end
  a_mark_order: assert property (@(posedge clk) disable iff (!rst_n)
    (front_r <= rear_r) && (int'(rear_r) <= DEPTH))
    else $error("deque marks out of order");

  // A slot write and a slot read never share a cycle
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr_en && ram_rd_en))
    else $error("slot write and read in the same cycle");

  // A read issues only for a request that reaches stage 1 with RAM data
  a_read_tag: assert property (@(posedge clk) disable iff (!rst_n)
    ram_rd_en |=> (s1_valid_r && s1_meta_r.from_ram))
    else $error("slot read without matching stage 1 tag");

  // A stalled response holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_tdata)))
    else $error("stalled response changed");

  // A refused request leaves the marks unchanged
  a_refuse_still: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (s1_meta_nxt.status != ST_DONE)) |=>
      ($stable(front_r) && $stable(rear_r)))
    else $error("refused request moved a mark");

endmodule

>>> tb/deque_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_result_checker
// Watches the request, response and size-register ports of the deque, keeps
// its own copy of the marks, slots and size limit, works out the response of
// every accepted request and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module deque_result_checker
  import ldq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,     // [1:0] mode, [33:2] value_in
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,    // [31:0] value_out, [33:32] status,
                                          // [38:34] occupancy
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,  // active_size
  output int unsigned       responses_owed,
  output int unsigned       fail_count
);

  localparam int PRINT_CAP = 40;

  typedef struct {
    logic [DATA_WIDTH-1:0] word;
    status_t               status;
    logic [OCC_W-1:0]      occ;
  } deque_resp_t;

  logic [DATA_WIDTH-1:0] slot_copy [DEPTH];
  logic [MARK_W-1:0]     head_mark;
  logic [MARK_W-1:0]     tail_mark;
  logic [SIZE_W-1:0]     size_limit;
  deque_resp_t           deque_responses [$];
  int unsigned           responses_checked;

  // Print one line per mismatch (up to a cap) and count it
  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP)
      $display("MISMATCH at response %0d: %s", responses_checked, what);
    fail_count++;
  endtask

  // Apply one request to the local deque copy and return its response
  function automatic deque_resp_t deque_apply(input mode_t op,
                                              input logic [DATA_WIDTH-1:0] word);
    deque_resp_t         resp;
    logic                was_empty;
    int unsigned         span;
    logic [ADDR_W-1:0]   slot_idx;
    resp.word   = '1;
    resp.status = ST_DONE;
    was_empty   = (head_mark == tail_mark);
    // Sizes above the array depth behave as the full depth
    span = (size_limit > DEPTH) ? DEPTH : size_limit;
    case (op)
      MODE_PUSH_FRONT: begin
        if (head_mark == 0) begin
          resp.status = ST_FULL;
        end else begin
          slot_idx = head_mark[ADDR_W-1:0] - 1'b1;
          slot_copy[slot_idx] = word;
          head_mark = head_mark - 1'b1;
        end
      end
      MODE_PUSH_REAR: begin
        // Limit check comes first: an empty queue parked at the limit refuses
        if (tail_mark >= span) begin
          resp.status = ST_FULL;
        end else begin
          if (was_empty) begin
            head_mark = '0;
            tail_mark = '0;
          end
          tail_mark = tail_mark + 1'b1;
          slot_idx = tail_mark[ADDR_W-1:0] - 1'b1;
          slot_copy[slot_idx] = word;
        end
      end
      MODE_POP_FRONT: begin
        if (was_empty) begin
          resp.status = ST_EMPTY;
        end else begin
          head_mark = head_mark + 1'b1;
          slot_idx = head_mark[ADDR_W-1:0] - 1'b1;
          resp.word = slot_copy[slot_idx];
        end
      end
      default: begin
        if (was_empty) begin
          resp.status = ST_EMPTY;
        end else begin
          slot_idx = tail_mark[ADDR_W-1:0] - 1'b1;
          resp.word = slot_copy[slot_idx];
          tail_mark = tail_mark - 1'b1;
        end
      end
    endcase
    resp.occ = tail_mark - head_mark;
    return resp;
  endfunction

  // Track size writes, check responses, then queue up the new request
  always @(posedge clk) begin
    deque_resp_t owed;
    if (!rst_n) begin
      head_mark  = '0;
      tail_mark  = '0;
      size_limit = SIZE_W'(SIZE_RST);
      deque_responses.delete();
    end else begin
      if (cfg_wr_en)
        size_limit = cfg_wr_data;

      if (out_tvalid && out_tready) begin
        if (deque_responses.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          owed = deque_responses.pop_front();
          if (out_tdata[DATA_WIDTH-1:0] !== owed.word)
            report_mismatch($sformatf("value_out %h, want %h",
                                      out_tdata[DATA_WIDTH-1:0], owed.word));
          if (out_tdata[DATA_WIDTH +: STATUS_W] !== owed.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_tdata[DATA_WIDTH +: STATUS_W], owed.status));
          if (out_tdata[DATA_WIDTH+STATUS_W +: OCC_W] !== owed.occ)
            report_mismatch($sformatf("occupancy %0d, want %0d",
                                      out_tdata[DATA_WIDTH+STATUS_W +: OCC_W], owed.occ));
        end
        responses_checked++;
      end

      if (in_tvalid && in_tready)
        deque_responses.push_back(deque_apply(mode_t'(in_tdata[MODE_W-1:0]),
                                              in_tdata[MODE_W +: DATA_WIDTH]));
    end
    responses_owed <= deque_responses.size();
  end

endmodule

>>> tb/linear_array_deque_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_array_deque_core_test
// Drives the deque with a short directed sequence (empty and full refusals,
// extreme words, size lowered under the rear, out-of-range sizes) and then
// runs of fill- and drain-heavy random requests under a sweep of sizes, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module linear_array_deque_core_test;
  import ldq_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 90;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata    = '0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_wr_en   = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;

  int unsigned responses_owed;
  int unsigned fail_count;
  int unsigned requests_sent = 0;
  int unsigned sizes_written = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_left     = 0;
  int unsigned calm_left     = 0;
  bit          steady_source = 1'b0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  linear_array_deque_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  deque_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .responses_owed (responses_owed),
    .fail_count     (fail_count)
  );

  // Throttle the response side: short stalls, a few long ones, calm stretches
  always @(posedge clk) begin : sink_throttle
    int unsigned pick;
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (calm_left != 0) begin
      calm_left  <= calm_left - 1;
      out_tready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        out_tready <= 1'b0;
        hold_left  <= $urandom_range(0, 3);
      end else if (pick < 23) begin
        out_tready <= 1'b0;
        hold_left  <= $urandom_range(15, 60);
      end else if (pick < 28) begin
        out_tready <= 1'b1;
        calm_left  <= $urandom_range(20, 120);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Drop the run when neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no traffic for %0d cycles, %0d responses outstanding",
               IDLE_LIMIT, responses_owed);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Gap before the next request: mostly none or short, now and then long
  function automatic int unsigned source_gap();
    int unsigned pick;
    if (steady_source)
      return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      return 0;
    if (pick < 88)
      return $urandom_range(1, 3);
    if (pick < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Data word with a bias toward the extremes
  function automatic logic [DATA_WIDTH-1:0] random_word();
    case ($urandom_range(0, 19))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // Present one request and hold it until the deque takes it
  task automatic send_request(input mode_t op, input logic [DATA_WIDTH-1:0] word);
    int unsigned gap;
    gap = source_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({word, op});
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  // Wait for the deque to go idle, then write active_size
  task automatic write_size(input logic [SIZE_W-1:0] size);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (responses_owed != 0);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sizes_written++;
  endtask

  // Alternate fill-heavy and drain-heavy runs so both ends hit full and empty
  task automatic random_phase(input int unsigned count);
    int unsigned sent;
    int unsigned run_len;
    int unsigned pick;
    bit          filling;
    mode_t       op;
    steady_source = ($urandom_range(0, 3) == 0);
    sent = 0;
    while (sent < count) begin
      filling = 1'($urandom_range(0, 1));
      run_len = $urandom_range(4, 24);
      repeat (run_len) begin
        pick = $urandom_range(0, 99);
        if ((pick < 85) == filling)
          op = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
        send_request(op, random_word());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty pops, refused push front at the array start, extreme words
    send_request(MODE_POP_FRONT, '0);
    send_request(MODE_POP_REAR, 32'h1234_5678);
    send_request(MODE_PUSH_FRONT, 32'hDEAD_BEEF);
    send_request(MODE_PUSH_REAR, 32'h7FFF_FFFF);
    send_request(MODE_PUSH_REAR, 32'h8000_0000);
    send_request(MODE_PUSH_REAR, '1);
    send_request(MODE_PUSH_REAR, '0);
    send_request(MODE_PUSH_FRONT, 32'h0F0F_0F0F);
    send_request(MODE_POP_FRONT, '0);
    send_request(MODE_POP_FRONT, '1);
    send_request(MODE_PUSH_FRONT, 32'h5555_5555);
    send_request(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
    send_request(MODE_POP_REAR, '0);

    // Size lowered under the rear mark, then drain to an empty queue at the limit
    write_size(SIZE_W'(2));
    send_request(MODE_PUSH_REAR, 32'h0000_0001);
    send_request(MODE_POP_FRONT, '0);
    send_request(MODE_POP_FRONT, '0);
    send_request(MODE_POP_FRONT, '0);
    send_request(MODE_POP_REAR, '0);
    send_request(MODE_PUSH_REAR, 32'h0000_0002);
    send_request(MODE_PUSH_FRONT, 32'hC3C3_C3C3);
    send_request(MODE_POP_REAR, '0);

    // Zero size refuses every rear push; out-of-range size acts as full depth
    write_size(SIZE_W'(0));
    send_request(MODE_PUSH_REAR, 32'h0000_0003);
    write_size(SIZE_W'(31));
    send_request(MODE_PUSH_REAR, 32'h0000_0004);

    // Random runs under a sweep of sizes, extremes included
    write_size(SIZE_W'(16));
    random_phase(PHASE_ITEMS);
    write_size(SIZE_W'(1));
    random_phase(PHASE_ITEMS);
    write_size(SIZE_W'(17));
    random_phase(PHASE_ITEMS);
    write_size(SIZE_W'(0));
    random_phase(PHASE_ITEMS);
    write_size(SIZE_W'(31));
    random_phase(PHASE_ITEMS);
    write_size(SIZE_W'(8));
    random_phase(PHASE_ITEMS);
    write_size(SIZE_W'($urandom_range(1, 15)));
    random_phase(PHASE_ITEMS);
    write_size(SIZE_W'($urandom_range(0, 31)));
    random_phase(PHASE_ITEMS);
    write_size(SIZE_W'(16));
    random_phase(PHASE_ITEMS);

    // Let every response drain, then give the verdict
    in_tvalid <= 1'b0;
    do @(posedge clk); while (responses_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests over %0d size writes (0, 1, 2, 8, 16, 17, 31, random),",
             requests_sent, sizes_written);
    $display("with random request gaps and response stalls; %0d mismatches.", fail_count);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
